// ===== hw/rtl/abid_pkg.sv =====
package abid_pkg;

    localparam int REG_ID_BITS = 8;
    localparam int REG_FIELD_BITS = 8;
    localparam int REG_CMP_BITS = (REG_ID_BITS < REG_FIELD_BITS) ? REG_ID_BITS : REG_FIELD_BITS;
    localparam int HIST_DEPTH = 3;

    localparam logic signed [31:0] SAR_EXT_AMOUNT = 32'sd63;
    localparam logic [6:0] EXT_OPERAND_BITS = 7'd64;
    localparam logic [2:0] LEN_SHORT = 3'd3;
    localparam logic [2:0] LEN_LONG = 3'd4;

    typedef enum logic [2:0] {
        OP_OTHER = 3'd0,
        OP_CDQ   = 3'd1,
        OP_XOR   = 3'd2,
        OP_SUB   = 3'd3,
        OP_SAR   = 3'd4,
        OP_ADD   = 3'd5,
        OP_MOVSX = 3'd6,
        OP_MOVZX = 3'd7
    } t_opcode;

    typedef logic [REG_CMP_BITS-1:0] t_reg_id;

    typedef struct packed {
        logic               window_start;
        logic [2:0]         opcode;
        logic [7:0]         dest_reg;
        logic [7:0]         first_src_reg;
        logic [7:0]         second_src_reg;
        logic               second_is_immediate;
        logic signed [31:0] immediate_value;
        logic [6:0]         first_src_width;
        logic [63:0]        instr_address;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  abs_input_reg;
        logic [7:0]  abs_output_reg;
        logic [6:0]  operand_bits;
        logic [63:0] start_address;
        logic [63:0] end_address;
        logic [2:0]  sequence_length;
    } t_out_item;

    typedef struct packed {
        t_opcode            op;
        t_reg_id            dst;
        t_reg_id            a;
        t_reg_id            b;
        logic               immf;
        logic signed [31:0] imm;
        logic [6:0]         width;
        logic [63:0]        addr;
    } t_slot;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_match;

    function automatic logic pair_is(t_slot s, t_reg_id p, t_reg_id q);
        return ((s.a == p) && (s.b == q)) || ((s.a == q) && (s.b == p));
    endfunction

    function automatic t_slot to_slot(t_in_item it);
        t_slot s;
        s.op   = t_opcode'(it.opcode);
        s.dst  = t_reg_id'(it.dest_reg);
        s.a    = t_reg_id'(it.first_src_reg);
        s.b    = t_reg_id'(it.second_src_reg);
        s.immf = it.second_is_immediate;
        s.imm  = it.immediate_value;
        s.width = it.first_src_width;
        s.addr = it.instr_address;
        return s;
    endfunction

endpackage

// ===== hw/rtl/branchless_abs_idiom_detector_unit.sv =====
// an accepted item is held in the input register until the output register can take its result
// throughput: one item per cycle while i_out_ready does not stall the output register
// items that complete no sequence produce no result
// reset: synchronous active-low i_rst_n empties the pipeline and the instruction
// history; history contents are only read once written
module branchless_abs_idiom_detector_unit import abid_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      advance;
    t_slot     cur_slot;
    t_slot     hist [HIST_DEPTH];
    logic [1:0] hist_count;
    t_match    match;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign cur_slot   = to_slot(r_in_item);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    abid_history u_history (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (advance),
        .i_window_start (r_in_item.window_start),
        .i_slot         (cur_slot),
        .o_slot         (hist),
        .o_count        (hist_count)
    );

    abid_match u_match (
        .i_hist         (hist),
        .i_count        (hist_count),
        .i_window_start (r_in_item.window_start),
        .i_cur          (cur_slot),
        .o_match        (match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= match.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && match.valid) begin
            r_out_item <= match.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_len_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.sequence_length == LEN_SHORT)
                         || (o_out_item.sequence_length == LEN_LONG)))
        else $error("bad sequence length");

    a_long_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.sequence_length == LEN_LONG))
            |-> (o_out_item.operand_bits == EXT_OPERAND_BITS))
        else $error("extension form must report full width");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_in_ready)
        else $error("empty input stage must take an item");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |=> r_in_valid)
        else $error("stalled item lost");

endmodule

// ===== hw/rtl/abid_history.sv =====
module abid_history import abid_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_load,
    input  logic  i_window_start,
    input  t_slot i_slot,
    output t_slot o_slot [HIST_DEPTH],
    output logic [1:0] o_count
);

    t_slot      r_slot [HIST_DEPTH];
    logic [1:0] r_count;
    logic [1:0] n_count;

    // newest entry sits at the top index
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < HIST_DEPTH - 1; i++) begin
                r_slot[i] <= r_slot[i+1];
            end
            r_slot[HIST_DEPTH-1] <= i_slot;
        end
    end

    always_comb begin
        if (i_window_start) begin
            n_count = 2'd1;
        end else if (r_count == 2'(HIST_DEPTH)) begin
            n_count = r_count;
        end else begin
            n_count = r_count + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else if (i_load) begin
            r_count <= n_count;
        end
    end

    assign o_slot  = r_slot;
    assign o_count = r_count;

endmodule

// ===== hw/rtl/abid_match.sv =====
module abid_match import abid_pkg::*; (
    input  t_slot      i_hist [HIST_DEPTH],
    input  logic [1:0] i_count,
    input  logic       i_window_start,
    input  t_slot      i_cur,
    output t_match     o_match
);

    logic [1:0] eff_count;
    logic       m4;
    logic       m3_cdq;
    logic       m3_sar;
    logic       sar_ok;
    t_slot      w0, w1, w2, v0, v1;

    always_comb begin
        eff_count = i_window_start ? 2'd0 : i_count;
        w0 = i_hist[0];
        w1 = i_hist[1];
        w2 = i_hist[2];
        v0 = i_hist[1];
        v1 = i_hist[2];

        m4 = (eff_count == 2'd3)
            && ((w0.op == OP_MOVSX) || (w0.op == OP_MOVZX))
            && (w1.op == OP_SAR) && w1.immf && (w1.imm == SAR_EXT_AMOUNT)
            && (w1.a == w0.dst)
            && (w2.op == OP_XOR) && pair_is(w2, w0.a, w1.dst)
            && (i_cur.op == OP_SUB) && (i_cur.a == w2.dst) && (i_cur.b == w1.dst);

        m3_cdq = (v0.op == OP_CDQ)
            && (v1.op == OP_XOR) && (v1.dst == v0.a) && pair_is(v1, v0.a, v0.dst)
            && (i_cur.op == OP_SUB) && (i_cur.a == v1.dst) && (i_cur.b == v0.dst);

        sar_ok = (v0.op == OP_SAR) && v0.immf
            && (v0.imm == ($signed(32'(v0.width)) - 32'sd1));

        m3_sar = sar_ok && pair_is(v1, v0.a, v0.dst)
            && (((v1.op == OP_XOR) && (i_cur.op == OP_SUB))
                || ((v1.op == OP_ADD) && (i_cur.op == OP_XOR)))
            && pair_is(i_cur, v1.dst, v0.dst);

        o_match.item.abs_output_reg = 8'(i_cur.dst);
        o_match.item.end_address    = i_cur.addr;
        if (m4) begin
            o_match.valid                = 1'b1;
            o_match.item.abs_input_reg   = 8'(w0.a);
            o_match.item.operand_bits    = EXT_OPERAND_BITS;
            o_match.item.start_address   = w0.addr;
            o_match.item.sequence_length = LEN_LONG;
        end else begin
            o_match.valid                = (eff_count >= 2'd2) && (m3_cdq || m3_sar);
            o_match.item.abs_input_reg   = 8'(v0.a);
            o_match.item.operand_bits    = v0.width;
            o_match.item.start_address   = v0.addr;
            o_match.item.sequence_length = LEN_SHORT;
        end
    end

endmodule
